[hw/rtl/sgts_pkg.sv]
`default_nettype none

package sgts_pkg;

  // Field and datapath widths
  localparam int unsigned SampleW  = 24;
  localparam int unsigned TargetW  = 16;
  localparam int unsigned GainW    = 32;
  localparam int unsigned CoeffW   = 16;
  localparam int unsigned SqW      = 32;
  localparam int unsigned FracBits = 27;
  localparam int unsigned EntryW   = 23;
  localparam int unsigned LaneStg  = 5;

  localparam logic [TargetW-1:0] TargetReset = 16'h1000;
  localparam logic [GainW-1:0]   GainReset   = 32'h1000_0000;
  localparam logic [63:0]        Q31One      = 64'h0000_0000_8000_0000;
  localparam logic [63:0]        FullScale64 = 64'd8388607;

  typedef struct packed {
    logic signed [SampleW-1:0] left_sample;
    logic signed [SampleW-1:0] right_sample;
  } in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] left_out;
    logic signed [SampleW-1:0] right_out;
  } out_t;

  // Load enables for the lane stages, first stage in bit 0
  typedef logic [LaneStg-1:0] lane_en_t;

  // Shift-subtract division; the quotient must fit in 32 bits
  function automatic logic [31:0] udiv32(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [31:0] quo;
    rem = num;
    quo = '0;
    for (int b = 31; b >= 0; b--) begin
      if (rem >= (den << b)) begin
        rem    = rem - (den << b);
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // One tanh table point: round(2^23 * tanh(8 * idx / depth)), limited to full scale
  function automatic logic [EntryW-1:0] tanh_entry(input int unsigned depth,
                                                   input int unsigned idx);
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        u;
    logic [63:0]        num;
    logic [63:0]        den;
    logic [63:0]        t;
    logic signed [63:0] sum;
    x    = 64'(udiv32(64'(idx) << 31, 64'(depth)));
    sum  = signed'(Q31One);
    term = Q31One;
    // e^(-x) by a truncated Taylor series
    for (int k = 1; k <= 20; k++) begin
      term = 64'(udiv32((term * x) >> 31, 64'(k)));
      if ((k & 1) != 0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    if (sum > signed'(Q31One)) begin
      sum = signed'(Q31One);
    end
    u = unsigned'(sum);
    // raise to the 16th power with rounding
    for (int s = 0; s < 4; s++) begin
      u = (u * u + (64'd1 << 30)) >> 31;
    end
    if (u > Q31One) begin
      u = Q31One;
    end
    num = Q31One - u;
    den = Q31One + u;
    t   = 64'(udiv32((num << 23) + (den >> 1), den));
    if (t > FullScale64) begin
      t = FullScale64;
    end
    return t[EntryW-1:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/sgts_gain.sv]
`default_nettype none

module sgts_gain #(
  parameter int unsigned SMOOTH_COEFF = 66
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic                          en0_i,
  input  wire logic                          en1_i,
  input  wire logic [sgts_pkg::TargetW-1:0]  target_i,
  input  wire sgts_pkg::in_t                 frame_i,
  output sgts_pkg::in_t                      frame_o,
  output logic [sgts_pkg::SqW-1:0]           sq_o
);

  localparam logic [sgts_pkg::CoeffW-1:0] Coeff = sgts_pkg::CoeffW'(SMOOTH_COEFF);

  logic [sgts_pkg::GainW-1:0]                 gain_q, gain_d;
  logic [sgts_pkg::GainW-1:0]                 tgt;
  logic [sgts_pkg::GainW-1:0]                 diff;
  logic [sgts_pkg::GainW+sgts_pkg::CoeffW-1:0] step_prod;
  logic [sgts_pkg::GainW-1:0]                 step;
  logic                                       up;
  logic [2*sgts_pkg::GainW-1:0]               sq_prod;
  sgts_pkg::in_t                              frame0_q;
  sgts_pkg::in_t                              frame1_q;
  logic [sgts_pkg::SqW-1:0]                   sq_q;

  // One-pole step toward the target, truncated toward zero
  always_comb begin
    tgt       = {target_i, 16'h0000};
    up        = (tgt >= gain_q);
    diff      = up ? (tgt - gain_q) : (gain_q - tgt);
    step_prod = diff * Coeff;
    step      = step_prod[sgts_pkg::GainW+15:16];
    gain_d    = up ? (gain_q + step) : (gain_q - step);
  end

  // Advance the smoothed gain once per accepted frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= sgts_pkg::GainReset;
    end else if (accept_i) begin
      gain_q <= gain_d;
    end
  end

  // Hold the frame beside its gain
  always_ff @(posedge clk_i) begin
    if (en0_i) begin
      frame0_q <= frame_i;
    end
  end

  // Square the gain: Q4.28 squared, keep Q8.24
  assign sq_prod = gain_q * gain_q;

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      sq_q     <= sq_prod[2*sgts_pkg::GainW-1:sgts_pkg::GainW];
      frame1_q <= frame0_q;
    end
  end

  assign frame_o = frame1_q;
  assign sq_o    = sq_q;

endmodule

`default_nettype wire

[hw/rtl/sgts_lane.sv]
`default_nettype none

module sgts_lane #(
  parameter int unsigned TANH_TABLE_DEPTH = 1024
) (
  input  wire logic                                clk_i,
  input  wire sgts_pkg::lane_en_t                  en_i,
  input  wire logic signed [sgts_pkg::SampleW-1:0] sample_i,
  input  wire logic [sgts_pkg::SqW-1:0]            sq_i,
  output logic signed [sgts_pkg::SampleW-1:0]      result_o
);

  localparam int unsigned DepthW = $clog2(TANH_TABLE_DEPTH + 1);
  localparam int unsigned QW     = sgts_pkg::SampleW + sgts_pkg::SqW - 23;
  localparam int unsigned PW     = QW + DepthW;
  localparam int unsigned KW     = PW - sgts_pkg::FracBits;
  localparam int unsigned EW     = sgts_pkg::EntryW;
  localparam int unsigned FW     = sgts_pkg::FracBits;
  localparam int unsigned SW     = sgts_pkg::SampleW;
  localparam logic [DepthW-1:0] DepthV    = DepthW'(TANH_TABLE_DEPTH);
  localparam logic [KW-1:0]     DepthK    = KW'(TANH_TABLE_DEPTH);
  localparam logic [SW-1:0]     FullScale = 24'h7F_FFFF;

  // Constant tanh table over 0..8
  logic [EW-1:0] tab [TANH_TABLE_DEPTH+1];

  for (genvar i = 0; i <= TANH_TABLE_DEPTH; i++) begin : g_tab
    localparam logic [EW-1:0] Entry = sgts_pkg::tanh_entry(TANH_TABLE_DEPTH, i);
    assign tab[i] = Entry;
  end

  logic [SW-1:0]          raw;
  logic                   neg;
  logic [SW-1:0]          mag;
  logic [SW+sgts_pkg::SqW-1:0] drive_prod;
  logic [QW-1:0]          q0_q;
  logic                   neg0_q;
  logic [PW-1:0]          p_prod;
  logic [KW-1:0]          k1_q;
  logic [FW-1:0]          f1_q;
  logic                   neg1_q;
  logic                   sat;
  logic [DepthW-1:0]      idx;
  logic [DepthW-1:0]      idx1;
  logic [EW-1:0]          a2_q, b2_q;
  logic [FW-1:0]          f2_q;
  logic                   sat2_q, neg2_q;
  logic                   dneg;
  logic [EW-1:0]          absd;
  logic [EW+FW-1:0]       interp_prod;
  logic [EW-1:0]          a3_q, term3_q;
  logic                   dneg3_q, sat3_q, neg3_q;
  logic [SW-1:0]          r;
  logic [SW-1:0]          res;
  logic [SW-1:0]          res_q;

  // Take magnitude and multiply by the squared gain
  always_comb begin
    raw        = sample_i;
    neg        = raw[SW-1];
    mag        = neg ? (~raw + 24'd1) : raw;
    drive_prod = mag * sq_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      q0_q   <= drive_prod[SW+sgts_pkg::SqW-1:23];
      neg0_q <= neg;
    end
  end

  // Scale by the table depth and split into index and fraction
  assign p_prod = q0_q * DepthV;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      k1_q   <= p_prod[PW-1:FW];
      f1_q   <= p_prod[FW-1:0];
      neg1_q <= neg0_q;
    end
  end

  // Read both table points around the drive value
  always_comb begin
    sat  = (k1_q >= DepthK);
    idx  = sat ? '0 : k1_q[DepthW-1:0];
    idx1 = idx + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      a2_q   <= tab[idx];
      b2_q   <= tab[idx1];
      f2_q   <= f1_q;
      sat2_q <= sat;
      neg2_q <= neg1_q;
    end
  end

  // Interpolation product, truncated toward zero
  always_comb begin
    dneg        = (b2_q < a2_q);
    absd        = dneg ? (a2_q - b2_q) : (b2_q - a2_q);
    interp_prod = absd * f2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      a3_q    <= a2_q;
      term3_q <= interp_prod[EW+FW-1:FW];
      dneg3_q <= dneg;
      sat3_q  <= sat2_q;
      neg3_q  <= neg2_q;
    end
  end

  // Finish interpolation, clamp, and restore the sign
  always_comb begin
    if (dneg3_q) begin
      r = {1'b0, a3_q} - {1'b0, term3_q};
    end else begin
      r = {1'b0, a3_q} + {1'b0, term3_q};
    end
    if (sat3_q || (r > FullScale)) begin
      r = FullScale;
    end
    res = neg3_q ? (~r + 24'd1) : r;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      res_q <= res;
    end
  end

  assign result_o = signed'(res_q);

endmodule

`default_nettype wire

[hw/rtl/smoothed_gain_tanh_saturator_top.sv]
// Stereo tanh saturator with a smoothed drive gain.
// Input channel: in_valid_i/in_ready_o carry one stereo frame (left and right
// signed Q1.23) per transfer. Output channel: out_valid_o/out_ready_i carry the
// saturated frame. Both channels transfer when valid and ready are high.
// cfg_we_i writes cfg_wdata_i (unsigned Q4.12) as the target gain; write it
// only while no frame is in flight.
// Each accepted frame first moves the smoothed gain one step toward the target,
// then both channels pass through identical lanes: drive by the squared gain,
// interpolated tanh table lookup, sign restore.
// Throughput: one frame per clock while the receiver keeps out_ready_i high;
// the gain update is a loop through the single gain_q register and every later
// stage is a registered pipeline stage.
// Reset clears all stage valids, sets the target and smoothed gain to 1.0.
// When the receiver stalls, the output holds its frame and stages upstream
// keep filling until every stage is occupied, then in_ready_o drops.
`default_nettype none

module smoothed_gain_tanh_saturator_top #(
  parameter int unsigned SMOOTH_COEFF     = 66,
  parameter int unsigned TANH_TABLE_DEPTH = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire sgts_pkg::in_t                 in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output sgts_pkg::out_t                     out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [sgts_pkg::TargetW-1:0]  cfg_wdata_i
);

  localparam int unsigned NumStg = 2 + sgts_pkg::LaneStg;

  logic [NumStg-1:0]              vld_q, vld_d;
  logic [NumStg:0]                rdy;
  logic                           accept;
  logic [sgts_pkg::TargetW-1:0]   target_q;
  sgts_pkg::in_t                  frame;
  logic [sgts_pkg::SqW-1:0]       sq;
  sgts_pkg::lane_en_t             lane_en;
  logic signed [sgts_pkg::SampleW-1:0] left_res, right_res;

  // A stage loads when it is empty or its successor advances
  always_comb begin
    rdy[NumStg] = out_ready_i;
    for (int s = NumStg - 1; s >= 0; s--) begin
      rdy[s] = !vld_q[s] || rdy[s+1];
    end
    vld_d[0] = rdy[0] ? in_valid_i : vld_q[0];
    for (int s = 1; s < NumStg; s++) begin
      vld_d[s] = rdy[s] ? vld_q[s-1] : vld_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Target gain register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= sgts_pkg::TargetReset;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  assign accept     = in_valid_i && rdy[0];
  assign in_ready_o = rdy[0];
  assign lane_en    = rdy[NumStg-1:2];

  sgts_gain #(
    .SMOOTH_COEFF(SMOOTH_COEFF)
  ) u_gain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .en0_i    (rdy[0]),
    .en1_i    (rdy[1]),
    .target_i (target_q),
    .frame_i  (in_data_i),
    .frame_o  (frame),
    .sq_o     (sq)
  );

  sgts_lane #(
    .TANH_TABLE_DEPTH(TANH_TABLE_DEPTH)
  ) u_lane_left (
    .clk_i    (clk_i),
    .en_i     (lane_en),
    .sample_i (frame.left_sample),
    .sq_i     (sq),
    .result_o (left_res)
  );

  sgts_lane #(
    .TANH_TABLE_DEPTH(TANH_TABLE_DEPTH)
  ) u_lane_right (
    .clk_i    (clk_i),
    .en_i     (lane_en),
    .sample_i (frame.right_sample),
    .sq_i     (sq),
    .result_o (right_res)
  );

  // Merge the lane results into one output frame
  always_comb begin
    out_data_o.left_out  = left_res;
    out_data_o.right_out = right_res;
  end

  assign out_valid_o = vld_q[NumStg-1];

endmodule

`default_nettype wire
